@@ sv/masth_pkg.sv @@
// Shared types, command codes and register map for the multi-axis stepper homing block.
package masth_pkg;

	localparam int NUM_AXES_DEF = 4;
	localparam int OUT_AXES     = 4;
	localparam int PADDR_W      = 5;

	// command codes
	localparam logic [2:0] FN_TICK     = 3'd0;
	localparam logic [2:0] FN_SET_TGT  = 3'd1;
	localparam logic [2:0] FN_STOP     = 3'd2;
	localparam logic [2:0] FN_STOP_ALL = 3'd3;
	localparam logic [2:0] FN_HOME     = 3'd4;
	localparam logic [2:0] FN_HOME_ALL = 3'd5;

	// register indexes (byte address = 4 * index)
	localparam logic [2:0] REG_DEBOUNCE = 3'd0;
	localparam logic [2:0] REG_INTERVAL = 3'd1;
	localparam logic [2:0] REG_LEVEL    = 3'd2;
	localparam logic [2:0] REG_HOME0    = 3'd3;
	localparam logic [2:0] REG_HOME1    = 3'd4;
	localparam logic [2:0] REG_HOME2    = 3'd5;
	localparam logic [2:0] REG_HOME3    = 3'd6;

	typedef struct packed {
		logic [2:0]         func;
		logic [2:0]         axis_sel;
		logic signed [31:0] new_target;
		logic [3:0]         limit_raw;
		logic               motor_enabled;
		logic               estop_active;
	} in_t;

	typedef struct packed {
		logic [3:0]         step_pulses;
		logic [3:0]         dir_bits;
		logic [3:0]         moving_bits;
		logic [3:0]         homing_bits;
		logic [3:0]         homed_bits;
		logic [3:0]         limit_pressed_bits;
		logic signed [31:0] position;
		logic               invalid_cmd;
	} out_t;

	// per-axis entry kept in memory
	typedef struct packed {
		logic signed [31:0] cur;
		logic signed [31:0] tgt;
		logic [15:0]        deb;
		logic [15:0]        tmr;
	} axent_t;

	// per-axis flags kept in flops (all axes feed every result)
	typedef struct packed {
		logic mov;
		logic hom;
		logic hmd;
		logic dir;
	} axflags_t;

endpackage

@@ sv/masth_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module masth_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             wr_en,
	input  logic [AW-1:0]    wr_addr,
	input  logic [WIDTH-1:0] wr_data,
	input  logic             rd_en,
	input  logic [AW-1:0]    rd_addr,
	output logic [WIDTH-1:0] rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

@@ sv/masth_axis.sv @@
// Per-axis update: applies one command to one axis entry and its flags.
module masth_axis (
	input  logic [2:0]           func,
	input  logic                 hit,
	input  logic                 gate,
	input  logic                 pressed,
	input  logic [15:0]          dbn_ticks,
	input  logic [15:0]          hm_interval,
	input  logic signed [31:0]   home_pos,
	input  logic signed [31:0]   new_target,
	input  masth_pkg::axent_t    ent_in,
	input  masth_pkg::axflags_t  flg_in,
	output masth_pkg::axent_t    ent_out,
	output masth_pkg::axflags_t  flg_out,
	output logic                 step
);
	import masth_pkg::*;

	logic [15:0] deb_nx;
	logic [15:0] tmr_nx;
	logic        lt;
	logic        gt;

	assign deb_nx = !pressed ? 16'd0 :
		(ent_in.deb < dbn_ticks) ? ent_in.deb + 16'd1 : ent_in.deb;
	assign tmr_nx = ent_in.tmr + 16'd1;
	assign lt     = $signed(ent_in.cur) < $signed(ent_in.tgt);
	assign gt     = $signed(ent_in.cur) > $signed(ent_in.tgt);

	always_comb begin
		ent_out = ent_in;
		flg_out = flg_in;
		step    = 1'b0;
		case (func)
			FN_TICK: begin
				if (flg_in.hom) begin
					ent_out.deb = deb_nx;
					if (deb_nx >= dbn_ticks) begin
						// switch confirmed: load home and finish
						ent_out.cur = home_pos;
						ent_out.tgt = home_pos;
						flg_out.hom = 1'b0;
						flg_out.mov = 1'b0;
						flg_out.hmd = 1'b1;
					end else begin
						ent_out.tmr = tmr_nx;
						if (tmr_nx >= hm_interval) begin
							ent_out.tmr = 16'd0;
							flg_out.dir = 1'b0;
							step        = 1'b1;
						end
					end
				end else if (flg_in.mov) begin
					if (lt) begin
						flg_out.dir = 1'b1;
						step        = 1'b1;
						ent_out.cur = ent_in.cur + 32'sd1;
					end else if (gt) begin
						flg_out.dir = 1'b0;
						step        = 1'b1;
						ent_out.cur = ent_in.cur - 32'sd1;
					end
				end
			end
			FN_SET_TGT: begin
				if (hit) begin
					ent_out.tgt = new_target;
					flg_out.mov = 1'b1;
				end
			end
			FN_STOP, FN_STOP_ALL: begin
				if (hit || func == FN_STOP_ALL) begin
					ent_out.tgt = ent_in.cur;
					flg_out.mov = 1'b0;
					flg_out.hom = 1'b0;
				end
			end
			FN_HOME, FN_HOME_ALL: begin
				if (gate && (hit || func == FN_HOME_ALL)) begin
					ent_out.tgt = ent_in.cur;
					ent_out.deb = 16'd0;
					flg_out.mov = 1'b1;
					flg_out.hom = 1'b1;
					flg_out.hmd = 1'b0;
					flg_out.dir = 1'b0;
				end
			end
			default: begin
			end
		endcase
	end

endmodule

@@ sv/multi_axis_stepper_homing.sv @@
// Multi-axis stepper controller with limit-switch homing: top level.
// The result is registered in ST_FLUSH after the sweep over all axes; a new request is
// taken only once the block is back in ST_IDLE. The sweep reads, updates and
// writes back one axis entry per cycle through the single axis memory port pair.
// The next request is taken while a finished result still waits on out_stall.
// Reset (arst_n low): all axis state reads as zero, registers take their defaults.
module multi_axis_stepper_homing #(
	parameter int NUM_AXES = masth_pkg::NUM_AXES_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             in_valid,
	output logic                             in_stall,
	input  masth_pkg::in_t                   in_data,
	output logic                             out_valid,
	input  logic                             out_stall,
	output masth_pkg::out_t                  out_data,
	input  logic                             psel,
	input  logic                             penable,
	input  logic                             pwrite,
	input  logic [masth_pkg::PADDR_W-1:0]    paddr,
	input  logic [31:0]                      pwdata,
	output logic [31:0]                      prdata,
	output logic                             pready
);
	import masth_pkg::*;

	localparam int AW = (NUM_AXES > 1) ? $clog2(NUM_AXES) : 1;
	localparam logic [AW:0] CNT_END = (AW + 1)'(NUM_AXES);
	localparam logic [AW-1:0] LAST_AX = AW'(NUM_AXES - 1);
	localparam int WIDTH_ENT = $bits(axent_t);

	typedef enum logic [1:0] {ST_IDLE, ST_RUN, ST_FLUSH} state_t;

	state_t             state_q;
	in_t                cmd_q;
	logic [15:0]        dbn_q;
	logic [15:0]        itv_q;
	logic               lvl_q;
	logic signed [31:0] home_q [4];

	axflags_t           flg_q [NUM_AXES];
	logic [NUM_AXES-1:0] vld_q;
	logic [NUM_AXES-1:0] steps_q;
	logic signed [31:0] pos_q;
	logic [AW:0]        rd_cnt_q;
	logic               vld_s1;
	logic [AW-1:0]      ax_s1;
	out_t               out_q;
	logic               out_vld_q;

	logic               cfg_wr;
	logic               in_acc;
	logic               issue;
	logic               sel_ok;
	logic [AW-1:0]      sel_idx;
	logic               gate;
	logic [NUM_AXES-1:0] prs;
	logic signed [31:0] hv [NUM_AXES];
	logic [WIDTH_ENT-1:0] rd_raw;
	axent_t             ent_rd;
	axent_t             ent_nx;
	axflags_t           flg_nx;
	logic               step_nx;
	logic [3:0]         dir_o, mov_o, hom_o, hmd_o, lim_o;

	assign pready   = 1'b1;
	assign cfg_wr   = psel && penable && pwrite;
	assign in_acc   = in_valid && !in_stall;
	assign in_stall = (state_q != ST_IDLE);
	assign issue    = (state_q == ST_RUN) && (rd_cnt_q != CNT_END);
	assign sel_ok   = {1'b0, cmd_q.axis_sel} < 4'(NUM_AXES);
	assign sel_idx  = cmd_q.axis_sel[AW-1:0];
	assign gate     = cmd_q.motor_enabled && !cmd_q.estop_active;
	assign out_valid = out_vld_q;
	assign out_data  = out_q;

	// per-axis limit level and home value; axes past the fourth see a low limit input and home at zero
	for (genvar i = 0; i < NUM_AXES; i++) begin : g_ax
		if (i < 4) begin : g_lo
			assign prs[i] = (cmd_q.limit_raw[i] == lvl_q);
			assign hv[i]  = home_q[i];
		end else begin : g_hi
			assign prs[i] = (lvl_q == 1'b0);
			assign hv[i]  = 32'sd0;
		end
	end

	for (genvar i = 0; i < OUT_AXES; i++) begin : g_out
		if (i < NUM_AXES) begin : g_on
			assign dir_o[i] = flg_q[i].dir;
			assign mov_o[i] = flg_q[i].mov;
			assign hom_o[i] = flg_q[i].hom;
			assign hmd_o[i] = flg_q[i].hmd;
			assign lim_o[i] = prs[i];
		end else begin : g_off
			assign dir_o[i] = 1'b0;
			assign mov_o[i] = 1'b0;
			assign hom_o[i] = 1'b0;
			assign hmd_o[i] = 1'b0;
			assign lim_o[i] = 1'b0;
		end
	end

	always_comb begin
		case (paddr[4:2])
			REG_DEBOUNCE: prdata = {16'd0, dbn_q};
			REG_INTERVAL: prdata = {16'd0, itv_q};
			REG_LEVEL:    prdata = {31'd0, lvl_q};
			REG_HOME0:    prdata = home_q[0];
			REG_HOME1:    prdata = home_q[1];
			REG_HOME2:    prdata = home_q[2];
			REG_HOME3:    prdata = home_q[3];
			default:      prdata = 32'd0;
		endcase
	end

	masth_ram #(
		.WIDTH(WIDTH_ENT),
		.DEPTH(NUM_AXES),
		.AW   (AW)
	) u_ram (
		.clk    (clk),
		.wr_en  (vld_s1),
		.wr_addr(ax_s1),
		.wr_data(ent_nx),
		.rd_en  (issue),
		.rd_addr(rd_cnt_q[AW-1:0]),
		.rd_data(rd_raw)
	);

	// an entry never written reads as its reset value
	assign ent_rd = vld_q[ax_s1] ? axent_t'(rd_raw) : '0;

	masth_axis u_axis (
		.func       (cmd_q.func),
		.hit        (sel_ok && (sel_idx == ax_s1)),
		.gate       (gate),
		.pressed    (prs[ax_s1]),
		.dbn_ticks  (dbn_q),
		.hm_interval(itv_q),
		.home_pos   (hv[ax_s1]),
		.new_target (cmd_q.new_target),
		.ent_in     (ent_rd),
		.flg_in     (flg_q[ax_s1]),
		.ent_out    (ent_nx),
		.flg_out    (flg_nx),
		.step       (step_nx)
	);

	always_ff @(posedge clk) begin
		if (in_acc) begin
			cmd_q <= in_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dbn_q  <= 16'd10;
			itv_q  <= 16'd100;
			lvl_q  <= 1'b0;
			home_q <= '{default: 32'sd0};
		end else if (cfg_wr) begin
			case (paddr[4:2])
				REG_DEBOUNCE: dbn_q     <= pwdata[15:0];
				REG_INTERVAL: itv_q     <= pwdata[15:0];
				REG_LEVEL:    lvl_q     <= pwdata[0];
				REG_HOME0:    home_q[0] <= pwdata;
				REG_HOME1:    home_q[1] <= pwdata;
				REG_HOME2:    home_q[2] <= pwdata;
				REG_HOME3:    home_q[3] <= pwdata;
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			flg_q     <= '{default: '0};
			vld_q     <= '0;
			steps_q   <= '0;
			pos_q     <= 32'sd0;
			rd_cnt_q  <= '0;
			vld_s1    <= 1'b0;
			ax_s1     <= '0;
			out_q     <= '0;
			out_vld_q <= 1'b0;
		end else begin
			if (out_vld_q && !out_stall && state_q != ST_FLUSH) begin
				out_vld_q <= 1'b0;
			end
			vld_s1 <= issue;
			if (issue) begin
				ax_s1    <= rd_cnt_q[AW-1:0];
				rd_cnt_q <= rd_cnt_q + 1'b1;
			end
			if (vld_s1) begin
				flg_q[ax_s1]   <= flg_nx;
				vld_q[ax_s1]   <= 1'b1;
				steps_q[ax_s1] <= step_nx;
				if (sel_ok && sel_idx == ax_s1) begin
					pos_q <= ent_nx.cur;
				end
			end
			case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						rd_cnt_q <= '0;
						steps_q  <= '0;
						pos_q    <= 32'sd0;
						state_q  <= ST_RUN;
					end
				end
				ST_RUN: begin
					if (vld_s1 && ax_s1 == LAST_AX) begin
						state_q <= ST_FLUSH;
					end
				end
				ST_FLUSH: begin
					// hold the result until the output register frees up
					if (!out_vld_q || !out_stall) begin
						out_q.step_pulses        <= 4'(steps_q);
						out_q.dir_bits           <= dir_o;
						out_q.moving_bits        <= mov_o;
						out_q.homing_bits        <= hom_o;
						out_q.homed_bits         <= hmd_o;
						out_q.limit_pressed_bits <= lim_o;
						out_q.position           <= pos_q;
						out_q.invalid_cmd        <= (cmd_q.func == FN_HOME) && !sel_ok;
						out_vld_q                <= 1'b1;
						state_q                  <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	logic [NUM_AXES-1:0] hom_v, hmd_v, mov_v;
	for (genvar i = 0; i < NUM_AXES; i++) begin : g_chk
		assign hom_v[i] = flg_q[i].hom;
		assign hmd_v[i] = flg_q[i].hmd;
		assign mov_v[i] = flg_q[i].mov;
	end

	a_hom_hmd: assert property (@(posedge clk) disable iff (!arst_n)
		(hom_v & hmd_v) == '0)
		else $error("axis both homing and homed");

	a_hom_mov: assert property (@(posedge clk) disable iff (!arst_n)
		(hom_v & ~mov_v) == '0)
		else $error("homing axis not marked moving");

	a_out_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_vld_q) |-> $past(state_q == ST_FLUSH))
		else $error("result raised outside flush");

	a_acc_run: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc |=> (state_q == ST_RUN && rd_cnt_q == '0))
		else $error("accepted request did not start a sweep");

endmodule
